[hw/rtl/ntfsrl_pkg.sv]
// ntfsrl_pkg: shared types and constants for the NTFS run-list decoder.
// No dependencies; used by ntfsrl_byte_parser and ntfs_runlist_decoder_unit.
package ntfsrl_pkg;

	localparam int unsigned DISK_W      = 48;
	localparam int unsigned CLUSTER_W   = 64;
	localparam int unsigned COUNT_W     = 16;
	localparam int unsigned PADDR_W     = 3;
	localparam int unsigned PDATA_W     = 64;
	localparam int unsigned M_TDATA_W   = 280;
	localparam logic [DISK_W-1:0] DISK_CLUSTERS_RST = 48'd1048576;
	localparam logic [COUNT_W-1:0] COUNT_MAX        = '1;
	localparam logic [CLUSTER_W-1:0] NO_CLUSTER     = '1;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_LENGTH,
		PH_OFFSET
	} phase_t;

	// One parsed byte's worth of work handed to the run resolver.
	typedef struct packed {
		logic                 clear;
		logic                 finish;
		logic                 summary;
		logic                 sparse;
		logic [CLUSTER_W-1:0] delta;
		logic [CLUSTER_W-1:0] length;
	} run_req_t;

endpackage

[hw/rtl/ntfsrl_byte_parser.sv]
// ntfsrl_byte_parser: header/length/offset byte parsing for one run list.
// Holds the per-run gather state; emits a ntfsrl_pkg::run_req_t per byte.
// Depends on ntfsrl_pkg.
module ntfsrl_byte_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic [7:0]          data_byte,
	input  logic                list_start,
	output ntfsrl_pkg::run_req_t req
);

	ntfsrl_pkg::phase_t ph_q, ph_d, ph_e;
	logic [3:0]  len_left_q, len_left_d;
	logic [3:0]  off_left_q, off_left_d;
	logic [3:0]  off_width_q, off_width_d;
	logic [3:0]  pos_q, pos_d;
	logic [63:0] len_acc_q, len_acc_d;
	logic [63:0] dlt_acc_q, dlt_acc_d;
	logic [63:0] dlt_sx;

	// sign-extend the offset at its byte width; wider than 7 bytes is taken as is
	always_comb begin
		case (off_width_q)
			4'd1: dlt_sx = {{56{dlt_acc_d[7]}},  dlt_acc_d[7:0]};
			4'd2: dlt_sx = {{48{dlt_acc_d[15]}}, dlt_acc_d[15:0]};
			4'd3: dlt_sx = {{40{dlt_acc_d[23]}}, dlt_acc_d[23:0]};
			4'd4: dlt_sx = {{32{dlt_acc_d[31]}}, dlt_acc_d[31:0]};
			4'd5: dlt_sx = {{24{dlt_acc_d[39]}}, dlt_acc_d[39:0]};
			4'd6: dlt_sx = {{16{dlt_acc_d[47]}}, dlt_acc_d[47:0]};
			4'd7: dlt_sx = {{8{dlt_acc_d[55]}},  dlt_acc_d[55:0]};
			default: dlt_sx = dlt_acc_d;
		endcase
	end

	assign ph_e = list_start ? ntfsrl_pkg::PH_HEADER : ph_q;

	always_comb begin
		ph_d        = ph_e;
		len_left_d  = len_left_q;
		off_left_d  = off_left_q;
		off_width_d = off_width_q;
		pos_d       = pos_q;
		len_acc_d   = len_acc_q;
		dlt_acc_d   = dlt_acc_q;
		req         = '0;
		req.clear   = list_start;
		unique case (ph_e)
			ntfsrl_pkg::PH_LENGTH: begin
				if (!pos_q[3])
					len_acc_d[{pos_q[2:0], 3'b000} +: 8] = data_byte;
				pos_d      = pos_q + 4'd1;
				len_left_d = len_left_q - 4'd1;
				if (len_left_d == 4'd0) begin
					if (off_left_q == 4'd0) begin
						req.finish = 1'b1;
						ph_d       = ntfsrl_pkg::PH_HEADER;
					end else begin
						ph_d  = ntfsrl_pkg::PH_OFFSET;
						pos_d = 4'd0;
					end
				end
			end
			ntfsrl_pkg::PH_OFFSET: begin
				if (!pos_q[3])
					dlt_acc_d[{pos_q[2:0], 3'b000} +: 8] = data_byte;
				pos_d      = pos_q + 4'd1;
				off_left_d = off_left_q - 4'd1;
				if (off_left_d == 4'd0) begin
					req.finish = 1'b1;
					ph_d       = ntfsrl_pkg::PH_HEADER;
				end
			end
			ntfsrl_pkg::PH_HEADER: begin
				if (data_byte == 8'd0) begin
					req.summary = 1'b1;
				end else begin
					len_left_d  = data_byte[3:0];
					off_left_d  = data_byte[7:4];
					off_width_d = data_byte[7:4];
					len_acc_d   = '0;
					dlt_acc_d   = '0;
					pos_d       = 4'd0;
					ph_d        = (data_byte[3:0] == 4'd0) ? ntfsrl_pkg::PH_OFFSET
					                                      : ntfsrl_pkg::PH_LENGTH;
				end
			end
			default: ph_d = ntfsrl_pkg::PH_HEADER;
		endcase
		req.sparse = (off_width_q == 4'd0);
		req.length = len_acc_d;
		req.delta  = dlt_sx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q        <= ntfsrl_pkg::PH_HEADER;
			len_left_q  <= '0;
			off_left_q  <= '0;
			off_width_q <= '0;
			pos_q       <= '0;
			len_acc_q   <= '0;
			dlt_acc_q   <= '0;
		end else if (adv) begin
			ph_q        <= ph_d;
			len_left_q  <= len_left_d;
			off_left_q  <= off_left_d;
			off_width_q <= off_width_d;
			pos_q       <= pos_d;
			len_acc_q   <= len_acc_d;
			dlt_acc_q   <= dlt_acc_d;
		end
	end

endmodule

[hw/rtl/ntfs_runlist_decoder_unit.sv]
// ntfs_runlist_decoder_unit: byte-stream NTFS data-run list decoder, top level.
// Instantiates ntfsrl_byte_parser; uses ntfsrl_pkg.
//
// Takes one run-list byte per request on the slave stream (tuser marks the
// first byte of a new list) and returns one request on the master stream per
// completed run, plus a summary request (tlast high) for each zero header.
// A byte is accepted every cycle when the output side keeps up; each byte
// passes four register stages (input, cluster add and clamp, run check and
// totals, output) on its way to the master stream.
// Stalls on the master side fill empty stages first. disk_clusters sits at
// APB address 0 and may only be written while the decoder is idle.
module ntfs_runlist_decoder_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	// slave stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [7:0]                         s_tdata,   // [7:0] data_byte
	input  logic [0:0]                         s_tuser,   // [0] list_start
	// master stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [63:0] run_cluster, [127:64] run_clusters, [128] run_sparse,
	// [129] run_accepted, [130] is_fragmented, [146:131] fragment_count,
	// [210:147] first_cluster, [274:211] total_clusters, rest zero
	output logic [ntfsrl_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic                               m_tlast,   // list_end
	// APB config
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [ntfsrl_pkg::PADDR_W-1:0]     paddr,
	input  logic [ntfsrl_pkg::PDATA_W-1:0]     pwdata,
	output logic [ntfsrl_pkg::PDATA_W-1:0]     prdata,
	output logic                               pready
);

	logic [ntfsrl_pkg::DISK_W-1:0] disk_q;
	logic [63:0]                   disk64;

	// single register: every address decodes to disk_clusters
	assign pready = 1'b1;
	assign prdata = {{(ntfsrl_pkg::PDATA_W-ntfsrl_pkg::DISK_W){1'b0}}, disk_q};
	assign disk64 = {16'd0, disk_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_q <= ntfsrl_pkg::DISK_CLUSTERS_RST;
		end else if (psel && penable && pwrite && pready && (paddr == paddr)) begin
			disk_q <= pwdata[ntfsrl_pkg::DISK_W-1:0];
		end
	end

	// stage enables, bubbles collapse
	logic en1, en2, en3, en4;
	logic v1_s1, v2_s2, v3_s3, v4_q;

	assign en4      = !v4_q || m_tready;
	assign en3      = !v3_s3 || en4;
	assign en2      = !v2_s2 || en3;
	assign en1      = !v1_s1 || en2;
	assign s_tready = en1;

	// stage 1: input register
	logic [7:0] byte_s1;
	logic       start_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
		end else if (en1) begin
			v1_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser[0];
		end
	end

	ntfsrl_pkg::run_req_t req_d, req_s2;

	ntfsrl_byte_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (v1_s1 && en2),
		.data_byte  (byte_s1),
		.list_start (start_s1),
		.req        (req_d)
	);

	// stage 2: cluster add and clamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s2 <= 1'b0;
		end else if (en2) begin
			v2_s2 <= v1_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2)
			req_s2 <= req_d;
	end

	logic [63:0] prev_q, prev_e, cl_raw, cl_d, len_d;

	assign prev_e = req_s2.clear ? 64'd0 : prev_q;
	assign cl_raw = prev_e + req_s2.delta;
	assign cl_d   = (cl_raw > disk64) ? {36'd0, cl_raw[23:0], 4'd0} : cl_raw;
	assign len_d  = (req_s2.length > disk64) ? {32'd0, req_s2.length[23:0], 8'd0}
	                                         : req_s2.length;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (v2_s2 && en3) begin
			if (req_s2.finish)
				prev_q <= cl_d;
			else if (req_s2.clear)
				prev_q <= '0;
		end
	end

	// stage 3: range check, contiguity and totals
	logic        clear_s3, finish_s3, summary_s3, sparse_s3;
	logic [63:0] cl_s3, len_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_s3 <= 1'b0;
		end else if (en3) begin
			v3_s3 <= v2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			clear_s3   <= req_s2.clear;
			finish_s3  <= req_s2.finish;
			summary_s3 <= req_s2.summary;
			sparse_s3  <= req_s2.sparse;
			cl_s3      <= cl_d;
			len_s3     <= len_d;
		end
	end

	logic                            have_q, have_e, have_d;
	logic                            frag_q, frag_e, frag_d;
	logic [ntfsrl_pkg::COUNT_W-1:0]  tally_q, tally_e, tally_d;
	logic [63:0]                     start_q, start_e, start_d;
	logic [63:0]                     sum_q, sum_e, sum_d;
	logic [63:0]                     solid_q, solid_e, solid_d;
	logic [63:0]                     end_q, end_d;
	logic                            run_ok;

	assign have_e  = clear_s3 ? 1'b0 : have_q;
	assign frag_e  = clear_s3 ? 1'b0 : frag_q;
	assign tally_e = clear_s3 ? '0 : tally_q;
	assign start_e = clear_s3 ? ntfsrl_pkg::NO_CLUSTER : start_q;
	assign sum_e   = clear_s3 ? 64'd0 : sum_q;
	assign solid_e = clear_s3 ? 64'd0 : solid_q;

	assign run_ok = (cl_s3 < disk64) && (len_s3 != 64'd0) && (len_s3 < disk64);

	always_comb begin
		have_d  = have_e;
		frag_d  = frag_e;
		tally_d = tally_e;
		start_d = start_e;
		sum_d   = sum_e;
		solid_d = solid_e;
		end_d   = end_q;
		if (finish_s3 && run_ok) begin
			if (tally_e != ntfsrl_pkg::COUNT_MAX)
				tally_d = tally_e + 1'b1;
			if (!sparse_s3) begin
				if (have_e && (end_q != cl_s3))
					frag_d = 1'b1;
				solid_d = len_s3;
			end
			end_d  = cl_s3 + (sparse_s3 ? solid_e : len_s3);
			have_d = 1'b1;
			if (start_e == ntfsrl_pkg::NO_CLUSTER)
				start_d = cl_s3;
			sum_d = sum_e + len_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q  <= 1'b0;
			frag_q  <= 1'b0;
			tally_q <= '0;
			start_q <= ntfsrl_pkg::NO_CLUSTER;
			sum_q   <= '0;
			solid_q <= '0;
			end_q   <= '0;
		end else if (v3_s3 && en4) begin
			have_q  <= have_d;
			frag_q  <= frag_d;
			tally_q <= tally_d;
			start_q <= start_d;
			sum_q   <= sum_d;
			solid_q <= solid_d;
			end_q   <= end_d;
		end
	end

	// output register
	logic [63:0]                    o_cl_q, o_len_q, o_first_q, o_total_q;
	logic                           o_sparse_q, o_ok_q, o_frag_q, o_end_q;
	logic [ntfsrl_pkg::COUNT_W-1:0] o_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v4_q <= 1'b0;
		end else if (en4) begin
			v4_q <= v3_s3 && (finish_s3 || summary_s3);
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			o_cl_q     <= finish_s3 ? cl_s3 : 64'd0;
			o_len_q    <= finish_s3 ? len_s3 : 64'd0;
			o_sparse_q <= finish_s3 && sparse_s3;
			o_ok_q     <= finish_s3 && run_ok;
			o_frag_q   <= frag_d;
			o_count_q  <= tally_d;
			o_first_q  <= start_d;
			o_total_q  <= sum_d;
			o_end_q    <= summary_s3;
		end
	end

	assign m_tvalid = v4_q;
	assign m_tlast  = o_end_q;
	assign m_tdata  = {5'd0, o_total_q, o_first_q, o_count_q, o_frag_q, o_ok_q,
	                   o_sparse_q, o_len_q, o_cl_q};

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// tb: self-checking bench for ntfs_runlist_decoder_unit, an NTFS run-list byte decoder.
// Decodes each accepted byte in a behavioral model and checks every result field.
// Depends on ntfsrl_pkg and the decoder RTL.
module tb;

	localparam int GAP_MAX           = 6;
	localparam int DRAIN_CYCLES      = 12;
	localparam int CLAMP_END         = 400;
	localparam int LISTS_END         = 1500;
	localparam int TOTAL_BYTES       = 1850;
	localparam int REG_DISK_CLUSTERS = 0;
	localparam logic [63:0] CLAMP_MASK = 64'hFF_FFFF;

	// {list_start, data_byte}
	localparam logic [8:0] DIRECTED [21] = '{
		9'h111, 9'h005, 9'h010,
		9'h001, 9'h003,
		9'h011, 9'h002, 9'h005,
		9'h021, 9'h001, 9'h0FF, 9'h0FF,
		9'h010, 9'h001,
		9'h000,
		9'h112, 9'h007,
		9'h111, 9'h002, 9'h000,
		9'h000
	};

	typedef struct packed {
		logic [63:0] cluster;
		logic [63:0] length;
		logic        sparse;
		logic        accepted;
		logic        fragmented;
		logic [15:0] tally;
		logic [63:0] first_run;
		logic [63:0] sum_len;
		logic        is_end;
	} run_rec_t;

	logic                             clk      = 1'b0;
	logic                             arst_n   = 1'b0;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	logic [7:0]                       s_tdata  = '0;
	logic [0:0]                       s_tuser  = '0;
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [ntfsrl_pkg::M_TDATA_W-1:0] m_tdata;
	logic                             m_tlast;
	logic                             psel     = 1'b0;
	logic                             penable  = 1'b0;
	logic                             pwrite   = 1'b0;
	logic [ntfsrl_pkg::PADDR_W-1:0]   paddr    = '0;
	logic [ntfsrl_pkg::PDATA_W-1:0]   pwdata   = '0;
	logic [ntfsrl_pkg::PDATA_W-1:0]   prdata;
	logic                             pready;

	run_rec_t expected_runs [$];
	int       errors     = 0;
	int       bytes_sent = 0;
	bit       gaps_on    = 1'b1;
	bit       stall_on   = 1'b1;

	// decoder model state
	logic [ntfsrl_pkg::DISK_W-1:0]  disk_q;
	ntfsrl_pkg::phase_t             ph_q;
	logic [3:0]                     len_left, off_left, off_width, byte_pos;
	logic [63:0]                    len_acc, delta_acc, prev_cluster, last_cluster, last_len;
	logic                           seen_run, frag;
	logic [ntfsrl_pkg::COUNT_W-1:0] tally;
	logic [63:0]                    first_cl, len_total;

	ntfs_runlist_decoder_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void wipe_list();
		ph_q         = ntfsrl_pkg::PH_HEADER;
		len_left     = '0;
		off_left     = '0;
		off_width    = '0;
		byte_pos     = '0;
		len_acc      = '0;
		delta_acc    = '0;
		prev_cluster = '0;
		last_cluster = '0;
		last_len     = '0;
		seen_run     = 1'b0;
		tally        = '0;
		first_cl     = ntfsrl_pkg::NO_CLUSTER;
		len_total    = '0;
		frag         = 1'b0;
	endfunction

	function automatic void post_result(input logic [63:0] cl, input logic [63:0] len,
			input logic sparse, input logic ok, input logic is_end);
		run_rec_t r;
		r.cluster    = cl;
		r.length     = len;
		r.sparse     = sparse;
		r.accepted   = ok;
		r.fragmented = frag;
		r.tally      = tally;
		r.first_run  = first_cl;
		r.sum_len    = len_total;
		r.is_end     = is_end;
		expected_runs.push_back(r);
	endfunction

	function automatic void close_run();
		logic [63:0] delta, cl, len;
		int          w;
		logic        sparse, ok;
		delta  = delta_acc;
		w      = off_width > 8 ? 8 : int'(off_width);
		sparse = (off_width == 0);
		if (w > 0 && w < 8 && delta[8*w-1])
			delta |= ~64'd0 << (8 * w);
		cl = prev_cluster + delta;
		if (cl > disk_q)
			cl = (cl & CLAMP_MASK) << 4;
		len = len_acc;
		if (len > disk_q)
			len = (len & CLAMP_MASK) << 8;
		prev_cluster = cl;
		ok = cl < disk_q && len != 0 && len < disk_q;
		if (ok) begin
			if (tally != ntfsrl_pkg::COUNT_MAX)
				tally++;
			if (!sparse) begin
				if (seen_run && last_cluster + last_len != cl)
					frag = 1'b1;
				last_len = len;
			end
			last_cluster = cl;
			seen_run     = 1'b1;
			if (first_cl == ntfsrl_pkg::NO_CLUSTER)
				first_cl = cl;
			len_total += len;
		end
		ph_q = ntfsrl_pkg::PH_HEADER;
		post_result(cl, len, sparse, ok, 1'b0);
	endfunction

	function automatic void length_done();
		if (off_left == 0) begin
			close_run();
		end else begin
			ph_q     = ntfsrl_pkg::PH_OFFSET;
			byte_pos = '0;
		end
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic restart);
		if (restart)
			wipe_list();
		case (ph_q)
			ntfsrl_pkg::PH_LENGTH: begin
				if (byte_pos < 8)
					len_acc |= 64'(b) << (8 * byte_pos);
				byte_pos++;
				len_left--;
				if (len_left == 0)
					length_done();
			end
			ntfsrl_pkg::PH_OFFSET: begin
				if (byte_pos < 8)
					delta_acc |= 64'(b) << (8 * byte_pos);
				byte_pos++;
				off_left--;
				if (off_left == 0)
					close_run();
			end
			default: begin
				if (b == 8'd0) begin
					post_result('0, '0, 1'b0, 1'b0, 1'b1);
				end else begin
					len_left  = b[3:0];
					off_left  = b[7:4];
					off_width = b[7:4];
					len_acc   = '0;
					delta_acc = '0;
					byte_pos  = '0;
					if (len_left == 0)
						length_done();
					else
						ph_q = ntfsrl_pkg::PH_LENGTH;
				end
			end
		endcase
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_byte(input logic [7:0] b, input logic restart);
		int gap;
		gap = gaps_on ? $urandom_range(0, GAP_MAX) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= restart;
		do @(posedge clk); while (!s_tready);
		decode_byte(b, restart);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_runs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_disk(input logic [ntfsrl_pkg::DISK_W-1:0] value);
		logic [ntfsrl_pkg::PDATA_W-1:0] word;
		drain();
		word    = {16'($urandom), value};
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ntfsrl_pkg::PADDR_W'(8 * REG_DISK_CLUSTERS);
		pwdata  <= word;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		disk_q = word[ntfsrl_pkg::DISK_W-1:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// one well-formed run; cut sends only a prefix of its bytes
	task automatic send_run(input bit restart, input bit cut);
		logic [7:0]  run_bytes [$];
		logic [63:0] len_v, delta_v, hi_mask;
		int          nl, no, n;
		bit          hole;
		hole = ($urandom_range(0, 5) == 0);
		case ($urandom_range(0, 9))
			0:       len_v = 64'd0;
			1:       len_v = {$urandom, $urandom};
			2:       len_v = 64'($urandom);
			default: len_v = 64'($urandom_range(1, 400));
		endcase
		nl = 0;
		for (int i = 0; i < 8; i++)
			if (len_v[8*i +: 8] != 8'd0)
				nl = i + 1;
		if ($urandom_range(0, 4) == 0)
			nl += $urandom_range(1, 15 - nl);
		case ($urandom_range(0, 7))
			0, 1:    delta_v = last_cluster + last_len - prev_cluster;
			2:       delta_v = {$urandom, $urandom};
			3, 4:    delta_v = {$urandom, $urandom} % {16'd0, disk_q} - prev_cluster;
			default: delta_v = 64'($urandom_range(0, 1000)) - 64'd500;
		endcase
		// narrowest signed byte width that holds the delta
		no = 8;
		for (int w = 7; w >= 1; w--) begin
			hi_mask = ~64'd0 << (8 * w);
			if ((delta_v[8*w-1] ? (delta_v | hi_mask) : (delta_v & ~hi_mask)) == delta_v)
				no = w;
		end
		if ($urandom_range(0, 4) == 0)
			no += $urandom_range(1, 15 - no);
		if (hole)
			no = 0;
		if (nl == 0 && no == 0)
			nl = 1;
		run_bytes.push_back({4'(no), 4'(nl)});
		for (int i = 0; i < nl; i++)
			run_bytes.push_back(i < 8 ? len_v[8*i +: 8] : 8'($urandom));
		for (int i = 0; i < no; i++)
			run_bytes.push_back(i < 8 ? delta_v[8*i +: 8] : 8'($urandom));
		n = cut ? $urandom_range(1, run_bytes.size() - 1) : run_bytes.size();
		for (int i = 0; i < n; i++)
			send_byte(run_bytes[i], restart && i == 0);
	endtask

	task automatic send_list(input int runs);
		bit cut;
		for (int r = 0; r < runs; r++) begin
			cut = ($urandom_range(0, 19) == 0);
			send_run(r == 0, cut);
			if (cut)
				return;
			if ($urandom_range(0, 9) == 0)
				send_byte(8'd0, 1'b0);
			if ($urandom_range(0, 29) == 0)
				drain();
		end
		send_byte(8'd0, 1'b0);
	endtask

	task automatic test_directed();
		foreach (DIRECTED[i])
			send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
	endtask

	task automatic test_clamp_limits();
		logic [ntfsrl_pkg::DISK_W-1:0] bounds [5];
		bounds = '{48'd1, 48'hFFFF_FFFF_FFFF, 48'd4096, 48'd300,
			ntfsrl_pkg::DISK_CLUSTERS_RST};
		foreach (bounds[i]) begin
			set_disk(bounds[i]);
			repeat (3)
				send_list($urandom_range(2, 8));
		end
		while (bytes_sent < CLAMP_END)
			send_list(6);
	endtask

	task automatic test_random_lists();
		while (bytes_sent < LISTS_END) begin
			if ($urandom_range(0, 14) == 0) begin
				case ($urandom_range(0, 3))
					0:       set_disk(ntfsrl_pkg::DISK_CLUSTERS_RST);
					1:       set_disk(48'($urandom_range(1, 65535)));
					2:       set_disk(48'($urandom_range(1, 1 << 30)));
					default: set_disk({16'($urandom), $urandom} | 48'd1);
				endcase
			end
			gaps_on  = ($urandom_range(0, 3) != 0);
			stall_on = ($urandom_range(0, 3) != 0);
			send_list($urandom_range(1, 12));
		end
	endtask

	task automatic test_noise();
		set_disk(48'hFFFF_FFFF_FFFF);
		gaps_on  = 1'b1;
		stall_on = 1'b1;
		while (bytes_sent < TOTAL_BYTES)
			send_byte(($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom),
				$urandom_range(0, 15) == 0);
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		run_rec_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_runs.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: expected none, got %h", $time, m_tdata);
			end else begin
				want = expected_runs.pop_front();
				check_field("run_cluster", want.cluster, m_tdata[63:0]);
				check_field("run_clusters", want.length, m_tdata[127:64]);
				check_field("run_sparse", 64'(want.sparse), 64'(m_tdata[128]));
				check_field("run_accepted", 64'(want.accepted), 64'(m_tdata[129]));
				check_field("is_fragmented", 64'(want.fragmented), 64'(m_tdata[130]));
				check_field("fragment_count", 64'(want.tally), 64'(m_tdata[146:131]));
				check_field("first_cluster", want.first_run, m_tdata[210:147]);
				check_field("total_clusters", want.sum_len, m_tdata[274:211]);
				check_field("list_end", 64'(want.is_end), 64'(m_tlast));
			end
		end
	end

	// result sink with random stalls
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = stall_on ? $urandom_range(0, GAP_MAX) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	initial begin
		#3_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		disk_q = ntfsrl_pkg::DISK_CLUSTERS_RST;
		wipe_list();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_clamp_limits();
		test_random_lists();
		test_noise();
		s_tvalid <= 1'b0;
		for (int i = 0; i < 2000 && expected_runs.size() != 0; i++)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_runs.size() != 0) begin
			errors += expected_runs.size();
			$display("%0t: results missing: expected %0d more, got 0", $time,
				expected_runs.size());
		end
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[files.f]
hw/rtl/ntfsrl_pkg.sv
hw/rtl/ntfsrl_byte_parser.sv
hw/rtl/ntfs_runlist_decoder_unit.sv
sim/tb.sv
